@@ rtl/transfer_unit_receive_fsm_defines.svh @@
// Assertion macros used by the receive core module.
`ifndef TRANSFER_UNIT_RECEIVE_FSM_DEFINES_SVH
`define TRANSFER_UNIT_RECEIVE_FSM_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define XFER_RX_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("xfer_rx: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define XFER_RX_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("xfer_rx: next-cycle check failed");

`endif

@@ rtl/xfer_rx_pkg.sv @@
package xfer_rx_pkg;

  localparam logic [7:0] UnitSize  = 8'h1b;
  localparam logic [7:0] UnitData1 = 8'h1d;
  localparam logic [7:0] UnitData2 = 8'h1e;
  localparam logic [7:0] UnitData3 = 8'h1f;
  localparam logic [7:0] UnitDone  = 8'h15;

  localparam logic [23:0] ExpectedSizeReset = 24'd4096;

  typedef enum logic [2:0] {
    StOk              = 3'd0,
    StSizeMismatch    = 3'd1,
    StSizeUnexpected  = 3'd2,
    StDataUnexpected  = 3'd3,
    StDoneUnexpected  = 3'd4,
    StUnknown         = 3'd5,
    StOverflow        = 3'd6
  } status_e;

  typedef struct packed {
    logic [7:0] unit_type;
    logic [7:0] payload_first;
    logic [7:0] payload_second;
    logic [7:0] payload_third;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [1:0]  byte_count;
    logic [7:0]  data_first;
    logic [7:0]  data_second;
    logic [7:0]  data_third;
    logic [23:0] write_offset;
    logic        send_ack;
    logic        transfer_done;
  } out_item_t;

endpackage

@@ rtl/xfer_rx_in_reg.sv @@
module xfer_rx_in_reg (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  xfer_rx_pkg::in_item_t in_data_i,
  input  logic                 advance_i,
  output logic                 valid_o,
  output xfer_rx_pkg::in_item_t data_o
);

  logic                  valid_q, valid_d;
  xfer_rx_pkg::in_item_t data_q;
  logic                  accept;

  // Hold only while the held unit cannot move on this cycle.
  assign in_stall_o = valid_q && !advance_i;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      data_q <= in_data_i;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

@@ rtl/xfer_rx_core.sv @@
`include "transfer_unit_receive_fsm_defines.svh"

module xfer_rx_core (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_valid_i,
  input  logic [23:0]            cfg_data_i,
  input  logic                   advance_i,
  input  xfer_rx_pkg::in_item_t  item_i,
  output xfer_rx_pkg::out_item_t result_o
);

  typedef enum logic [1:0] {
    PhWaitSize = 2'd0,
    PhRecv     = 2'd1,
    PhWaitEnd  = 2'd2
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [23:0] count_q, count_d;
  logic [23:0] expected_q;

  logic [23:0] size_field;
  logic [1:0]  nbytes;
  logic [24:0] count_sum;
  logic        fits;
  logic        in_recv;
  logic        in_wait_end;

  assign size_field  = {item_i.payload_first, item_i.payload_second, item_i.payload_third};
  // Data type codes end in the byte count.
  assign nbytes      = item_i.unit_type[1:0];
  assign count_sum   = {1'b0, count_q} + {23'd0, nbytes};
  assign fits        = count_sum <= {1'b0, expected_q};
  assign in_recv     = (phase_q == PhRecv);
  assign in_wait_end = (phase_q == PhWaitEnd);

  always_comb begin
    phase_d  = phase_q;
    count_d  = count_q;
    result_o = '0;
    result_o.status = xfer_rx_pkg::StOk;
    case (item_i.unit_type) inside
      xfer_rx_pkg::UnitSize: begin
        if (in_recv || in_wait_end) begin
          result_o.status = xfer_rx_pkg::StSizeUnexpected;
        end else if (size_field == expected_q) begin
          phase_d = PhRecv;
          count_d = '0;
        end else begin
          result_o.status = xfer_rx_pkg::StSizeMismatch;
        end
      end
      xfer_rx_pkg::UnitData1, xfer_rx_pkg::UnitData2, xfer_rx_pkg::UnitData3: begin
        if (!in_recv) begin
          result_o.status = xfer_rx_pkg::StDataUnexpected;
        end else if (fits) begin
          result_o.byte_count   = nbytes;
          result_o.write_offset = count_q;
          result_o.data_first   = item_i.payload_first;
          result_o.data_second  = (nbytes >= 2'd2) ? item_i.payload_second : 8'd0;
          result_o.data_third   = (nbytes == 2'd3) ? item_i.payload_third : 8'd0;
          count_d = count_sum[23:0];
          if (count_sum[23:0] == expected_q) begin
            phase_d = PhWaitEnd;
            result_o.send_ack = 1'b1;
          end
        end else begin
          // Drop the transfer and wait for a new size unit.
          result_o.status = xfer_rx_pkg::StOverflow;
          phase_d = PhWaitSize;
          count_d = '0;
        end
      end
      xfer_rx_pkg::UnitDone: begin
        if (in_wait_end) begin
          result_o.transfer_done = 1'b1;
          result_o.send_ack      = 1'b1;
          phase_d = PhWaitSize;
        end else begin
          result_o.status = xfer_rx_pkg::StDoneUnexpected;
        end
      end
      default: begin
        result_o.status = xfer_rx_pkg::StUnknown;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PhWaitSize;
      count_q    <= '0;
      expected_q <= xfer_rx_pkg::ExpectedSizeReset;
    end else begin
      if (advance_i) begin
        phase_q <= phase_d;
        count_q <= count_d;
      end
      if (cfg_valid_i) begin
        expected_q <= cfg_data_i;
      end
    end
  end

  `XFER_RX_ASSERT_IMPL(a_done_acks, clk_i, rst_ni,
      advance_i && result_o.transfer_done, result_o.send_ack)
  `XFER_RX_ASSERT_IMPL(a_err_no_bytes, clk_i, rst_ni,
      advance_i && (result_o.status != xfer_rx_pkg::StOk), result_o.byte_count == 2'd0)
  `XFER_RX_ASSERT_IMPL(a_no_bytes_no_offset, clk_i, rst_ni,
      advance_i && (result_o.byte_count == 2'd0), result_o.write_offset == 24'd0)
  `XFER_RX_ASSERT_NEXT(a_ack_to_wait_end, clk_i, rst_ni,
      advance_i && result_o.send_ack && !result_o.transfer_done, phase_q == PhWaitEnd)

endmodule

@@ rtl/xfer_rx_out_reg.sv @@
module xfer_rx_out_reg (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   load_i,
  input  xfer_rx_pkg::out_item_t result_i,
  output logic                   free_o,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output xfer_rx_pkg::out_item_t out_data_o
);

  logic                   valid_q, valid_d;
  xfer_rx_pkg::out_item_t data_q;

  // Free when empty or when the held result transfers this cycle.
  assign free_o = !valid_q || !out_stall_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (!out_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= result_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

@@ rtl/transfer_unit_receive_fsm.sv @@
// Pipeline: input register, then result register; a unit moves on when the result register
// is free. Throughput: one unit per cycle while the output is not stalled.
// The phase/count update is a single 25-bit add and compare.
// Reset: asynchronous, active low; clears both valid flags, phase to wait-for-size,
// received count to 0 and expected size to 4096.
module transfer_unit_receive_fsm (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [23:0]            cfg_data_i,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  xfer_rx_pkg::in_item_t  in_data_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output xfer_rx_pkg::out_item_t out_data_o
);

  logic                   item_valid;
  xfer_rx_pkg::in_item_t  item;
  xfer_rx_pkg::out_item_t result;
  logic                   out_free;
  logic                   advance;

  assign cfg_ready_o = 1'b1;
  // Advance the held unit through the step logic into the result register.
  assign advance     = item_valid && out_free;

  xfer_rx_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .advance_i  (advance),
    .valid_o    (item_valid),
    .data_o     (item)
  );

  xfer_rx_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .advance_i   (advance),
    .item_i      (item),
    .result_o    (result)
  );

  xfer_rx_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (advance),
    .result_i    (result),
    .free_o      (out_free),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

@@ bench/tb_transfer_unit_receive_fsm.sv @@
module tb_transfer_unit_receive_fsm;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [7:0] UnitReserved = 8'h1c;
  localparam int         DrainCycles  = 4;
  localparam int         StallLimit   = 2000;

  typedef enum logic [1:0] {
    PhWaitSize = 2'd0,
    PhRecv     = 2'd1,
    PhWaitEnd  = 2'd2
  } rx_phase_e;

  class receive_tracker;
    logic [23:0]            size_cfg;
    rx_phase_e              phase;
    logic [23:0]            count;
    xfer_rx_pkg::out_item_t pending_results[$];
    int                     errors;

    function void init();
      size_cfg = xfer_rx_pkg::ExpectedSizeReset;
      phase    = PhWaitSize;
      count    = '0;
      errors   = 0;
    endfunction

    function void set_size(logic [23:0] v);
      size_cfg = v;
    endfunction

    function xfer_rx_pkg::out_item_t next_result(xfer_rx_pkg::in_item_t u);
      xfer_rx_pkg::out_item_t r;
      logic [24:0]            sum;
      logic [1:0]             n;
      r = '0;
      case (u.unit_type)
        xfer_rx_pkg::UnitSize: begin
          if (phase == PhRecv || phase == PhWaitEnd) begin
            r.status = xfer_rx_pkg::StSizeUnexpected;
          end else if ({u.payload_first, u.payload_second, u.payload_third} == size_cfg) begin
            phase = PhRecv;
            count = '0;
          end else begin
            r.status = xfer_rx_pkg::StSizeMismatch;
          end
        end
        xfer_rx_pkg::UnitData1, xfer_rx_pkg::UnitData2, xfer_rx_pkg::UnitData3: begin
          n = (u.unit_type == xfer_rx_pkg::UnitData1) ? 2'd1 :
              (u.unit_type == xfer_rx_pkg::UnitData2) ? 2'd2 : 2'd3;
          if (phase != PhRecv) begin
            r.status = xfer_rx_pkg::StDataUnexpected;
          end else begin
            sum = {1'b0, count} + {23'd0, n};
            if (sum <= {1'b0, size_cfg}) begin
              r.byte_count   = n;
              r.write_offset = count;
              r.data_first   = u.payload_first;
              if (n > 2'd1) r.data_second = u.payload_second;
              if (n > 2'd2) r.data_third = u.payload_third;
              count = sum[23:0];
              if (count == size_cfg) begin
                phase      = PhWaitEnd;
                r.send_ack = 1'b1;
              end
            end else begin
              // overflow aborts the transfer
              r.status = xfer_rx_pkg::StOverflow;
              phase    = PhWaitSize;
              count    = '0;
            end
          end
        end
        xfer_rx_pkg::UnitDone: begin
          if (phase == PhWaitEnd) begin
            r.transfer_done = 1'b1;
            r.send_ack      = 1'b1;
            phase           = PhWaitSize;
          end else begin
            r.status = xfer_rx_pkg::StDoneUnexpected;
          end
        end
        default: r.status = xfer_rx_pkg::StUnknown;
      endcase
      return r;
    endfunction

    function void note_unit(xfer_rx_pkg::in_item_t u);
      pending_results.push_back(next_result(u));
    endfunction

    task flag_mismatch(string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      errors++;
    endtask

    task check_result(xfer_rx_pkg::out_item_t got);
      xfer_rx_pkg::out_item_t want;
      if (pending_results.size() == 0) begin
        flag_mismatch($sformatf("result %h with nothing pending", got));
        return;
      end
      want = pending_results.pop_front();
      if (got.status !== want.status)
        flag_mismatch($sformatf("status %0d, want %0d", got.status, want.status));
      if (got.byte_count !== want.byte_count)
        flag_mismatch($sformatf("byte_count %0d, want %0d", got.byte_count, want.byte_count));
      if (got.data_first !== want.data_first)
        flag_mismatch($sformatf("data_first %h, want %h", got.data_first, want.data_first));
      if (got.data_second !== want.data_second)
        flag_mismatch($sformatf("data_second %h, want %h", got.data_second, want.data_second));
      if (got.data_third !== want.data_third)
        flag_mismatch($sformatf("data_third %h, want %h", got.data_third, want.data_third));
      if (got.write_offset !== want.write_offset)
        flag_mismatch($sformatf("write_offset %h, want %h", got.write_offset,
                                want.write_offset));
      if (got.send_ack !== want.send_ack)
        flag_mismatch($sformatf("send_ack %b, want %b", got.send_ack, want.send_ack));
      if (got.transfer_done !== want.transfer_done)
        flag_mismatch($sformatf("transfer_done %b, want %b", got.transfer_done,
                                want.transfer_done));
    endtask
  endclass

  logic                   clk_i       = 1'b0;
  logic                   rst_ni      = 1'b0;
  logic                   cfg_valid_i = 1'b0;
  logic                   cfg_ready_o;
  logic [23:0]            cfg_data_i  = '0;
  logic                   in_valid_i  = 1'b0;
  logic                   in_stall_o;
  xfer_rx_pkg::in_item_t  in_data_i   = '0;
  logic                   out_valid_o;
  logic                   out_stall_i = 1'b0;
  xfer_rx_pkg::out_item_t out_data_o;

  logic        in_fire  = 1'b0;
  logic        cfg_fire = 1'b0;
  int          send_idle_pct  = 0;
  int          recv_stall_pct = 0;
  int          units_sent     = 0;
  int          quiet_cycles   = 0;
  logic [23:0] cur_size       = xfer_rx_pkg::ExpectedSizeReset;

  receive_tracker tracker;

  transfer_unit_receive_fsm DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  always #1 clk_i = ~clk_i;

  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  // sample every transfer at the rising edge; watchdog on cycles without one
  always @(posedge clk_i) begin
    in_fire  <= rst_ni && in_valid_i && !in_stall_o;
    cfg_fire <= rst_ni && cfg_valid_i && cfg_ready_o;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) tracker.set_size(cfg_data_i);
      if (in_valid_i && !in_stall_o) tracker.note_unit(in_data_i);
      if (out_valid_o && !out_stall_i) tracker.check_result(out_data_o);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= StallLimit) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  function automatic xfer_rx_pkg::in_item_t make_unit(logic [7:0] t, logic [7:0] a,
                                                      logic [7:0] b, logic [7:0] c);
    xfer_rx_pkg::in_item_t u;
    u.unit_type      = t;
    u.payload_first  = a;
    u.payload_second = b;
    u.payload_third  = c;
    return u;
  endfunction

  function automatic xfer_rx_pkg::in_item_t random_unit(logic [7:0] t);
    return make_unit(t, 8'($urandom_range(255)), 8'($urandom_range(255)),
                     8'($urandom_range(255)));
  endfunction

  function automatic xfer_rx_pkg::in_item_t size_unit(logic [23:0] s);
    return make_unit(xfer_rx_pkg::UnitSize, s[23:16], s[15:8], s[7:0]);
  endfunction

  // called at a falling edge; returns at the falling edge after the transfer
  task automatic send_unit(xfer_rx_pkg::in_item_t u);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= u;
    do @(negedge clk_i); while (!in_fire);
    units_sent++;
  endtask

  // hold the sender until every result is back, then let the pipe settle
  task automatic drain();
    in_valid_i <= 1'b0;
    while (tracker.pending_results.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  task automatic write_size(logic [23:0] v);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(negedge clk_i); while (!cfg_fire);
    cfg_valid_i <= 1'b0;
    cur_size = v;
  endtask

  task automatic send_transfer();
    int          left;
    int          n;
    int          units;
    logic [7:0]  t;
    left  = int'(cur_size);
    units = 0;
    if ($urandom_range(9) == 0) send_unit(random_unit(xfer_rx_pkg::UnitSize));
    send_unit(size_unit(cur_size));
    while ((left > 0 || units == 0) && units < 24) begin
      if ($urandom_range(6) == 0) begin
        case ($urandom_range(3))
          0:       t = xfer_rx_pkg::UnitSize;
          1:       t = xfer_rx_pkg::UnitDone;
          default: t = 8'($urandom_range(255));
        endcase
        send_unit(random_unit(t));
      end
      n = $urandom_range(1, 3);
      if (n > left && left > 0 && $urandom_range(3) != 0) n = left;
      t = (n == 1) ? xfer_rx_pkg::UnitData1 :
          (n == 2) ? xfer_rx_pkg::UnitData2 : xfer_rx_pkg::UnitData3;
      send_unit(random_unit(t));
      left = (n > left) ? -1 : left - n;
      units++;
    end
    if (left == 0) begin
      send_unit(random_unit(xfer_rx_pkg::UnitDone));
      if ($urandom_range(7) == 0) send_unit(random_unit(xfer_rx_pkg::UnitDone));
    end
  endtask

  task automatic run_segment(logic [23:0] size, int n_items);
    int stop;
    write_size(size);
    stop = units_sent + n_items;
    while (units_sent < stop) begin
      send_transfer();
      if ($urandom_range(5) == 0) drain();
    end
  endtask

  task automatic run_directed();
    send_unit(make_unit(xfer_rx_pkg::UnitDone, 8'h00, 8'h00, 8'h00));
    send_unit(make_unit(xfer_rx_pkg::UnitData1, 8'hff, 8'hff, 8'hff));
    send_unit(make_unit(UnitReserved, 8'h12, 8'h34, 8'h56));
    send_unit(make_unit(8'h00, 8'h00, 8'h00, 8'h00));
    send_unit(make_unit(8'hff, 8'hff, 8'hff, 8'hff));
    send_unit(size_unit(xfer_rx_pkg::ExpectedSizeReset + 24'd1));
    send_unit(size_unit(xfer_rx_pkg::ExpectedSizeReset));
    send_unit(size_unit(xfer_rx_pkg::ExpectedSizeReset));
    send_unit(make_unit(xfer_rx_pkg::UnitDone, 8'h00, 8'h00, 8'h00));
    send_unit(make_unit(xfer_rx_pkg::UnitData3, 8'hff, 8'hff, 8'hff));
    send_unit(make_unit(xfer_rx_pkg::UnitData2, 8'h00, 8'h00, 8'h00));
    send_unit(make_unit(xfer_rx_pkg::UnitData1, 8'h5a, 8'ha5, 8'h3c));
    // shrink the size below the running count: next data overflows
    write_size(24'd4);
    send_unit(make_unit(xfer_rx_pkg::UnitData1, 8'h01, 8'h02, 8'h03));
    send_unit(size_unit(24'd4));
    send_unit(make_unit(xfer_rx_pkg::UnitData3, 8'ha5, 8'h5a, 8'hc3));
    send_unit(make_unit(xfer_rx_pkg::UnitData1, 8'h3c, 8'h77, 8'h88));
    send_unit(make_unit(xfer_rx_pkg::UnitData1, 8'h11, 8'h22, 8'h33));
    send_unit(size_unit(24'd4));
    send_unit(make_unit(xfer_rx_pkg::UnitDone, 8'hff, 8'hff, 8'hff));
    send_unit(size_unit(24'd4));
    send_unit(make_unit(xfer_rx_pkg::UnitData3, 8'h01, 8'h02, 8'h03));
    send_unit(make_unit(xfer_rx_pkg::UnitData2, 8'h04, 8'h05, 8'h06));
    write_size(24'd0);
    send_unit(size_unit(24'd0));
    send_unit(make_unit(xfer_rx_pkg::UnitData1, 8'h99, 8'h00, 8'h00));
    write_size(24'hffffff);
    send_unit(size_unit(24'hffffff));
    send_unit(make_unit(xfer_rx_pkg::UnitData3, 8'hfe, 8'hdc, 8'hba));
    send_unit(make_unit(xfer_rx_pkg::UnitDone, 8'h00, 8'h00, 8'h00));
  endtask

  initial begin
    logic [23:0] size;
    tracker = new();
    tracker.init();
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    for (int p = 0; p < 3; p++) begin
      send_idle_pct  = (p == 0) ? 38 : (p == 1) ? 59 : 0;
      recv_stall_pct = (p == 0) ? 59 : (p == 1) ? 38 : 0;
      if (p == 0) run_directed();
      for (int s = 0; s < 3; s++) begin
        size = 24'($urandom_range(1, 16));
        if (p == 0 && s == 1) size = 24'd0;
        if (p == 1 && s == 1) size = 24'hffffff;
        run_segment(size, 66);
      end
    end
    drain();
    if (tracker.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/xfer_rx_pkg.sv
rtl/xfer_rx_in_reg.sv
rtl/xfer_rx_core.sv
rtl/xfer_rx_out_reg.sv
rtl/transfer_unit_receive_fsm.sv
bench/tb_transfer_unit_receive_fsm.sv
